### sv/sliding_window_max_defines.svh
// assertion macros shared by the sliding window max rtl
`ifndef SLIDING_WINDOW_MAX_DEFINES_SVH
`define SLIDING_WINDOW_MAX_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/swm_pkg.sv
// package with types and constants of the sliding window max block
package swm_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int SAMPLE_W       = 32;
    localparam int WINDOW_W       = 7;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       seq_end;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] window_max;
        logic                       final_result;
    } t_out_word;

    // broadcast control to every cell of the chain
    typedef struct packed {
        logic                       step;
        logic                       drop;
        logic                       clear;
        logic signed [SAMPLE_W-1:0] sample;
    } t_cell_ctl;

endpackage

### sv/sliding_window_max.sv
// top level of the sliding window max block: control, window register and cell chain
// Streaming sliding-window maximum over signed 32-bit samples. Each input word carries
// one sample and a seq_end flag; once window_size samples of the current sequence have
// arrived, every sample yields one output word with the maximum of the latest
// window_size samples, and final_result marks the word of the sequence's last sample.
// A sequence shorter than the window yields nothing, and all state clears after the
// seq_end sample. window_size 0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX.
// Throughput is one sample per clock while o_stall is low: the deque lives in a row of
// WINDOW_MAX cells that compare against the new sample in parallel, so every sample is
// fully handled in the cycle it is accepted and its result sits in the output register
// in the cycle after. After window_size is lowered, the first sample may wait while the
// chain drops stale front candidates one cell per cycle.
module sliding_window_max #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [swm_pkg::WINDOW_W-1:0]      i_cfg_data,
    // sample channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  swm_pkg::t_in_word                 i_word,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output swm_pkg::t_out_word                o_word
);
    import swm_pkg::*;

    `include "sliding_window_max_defines.svh"

    // age and window counts reach WINDOW_MAX itself
    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int CW = (KW > WINDOW_W) ? KW : WINDOW_W;

    // window register
    logic [WINDOW_W-1:0] r_window;
    // samples seen in this sequence, saturating at the window
    logic [KW-1:0]       r_fill;
    logic [KW-1:0]       n_fill;
    // output register
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic [CW-1:0]       w_window_wide;
    logic [KW-1:0]       w_k;
    logic                w_accept;
    logic                w_drop;
    logic                w_trim;
    logic                w_produced;
    t_cell_ctl           w_ctl;

    // chain wiring, index WINDOW_MAX is the empty slot past the back
    logic                       w_valid   [WINDOW_MAX+1];
    logic signed [SAMPLE_W-1:0] w_value   [WINDOW_MAX+1];
    logic [KW-1:0]              w_age     [WINDOW_MAX+1];
    logic                       w_keep    [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] w_cand    [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]      w_valid_vec;

    // window register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_data;
        end
    end

    // effective window: zero acts as one, clamp at chain length
    always_comb begin
        w_window_wide = CW'(r_window);
        if (w_window_wide == '0) begin
            w_k = KW'(1);
        end else if (w_window_wide > CW'(WINDOW_MAX)) begin
            w_k = KW'(WINDOW_MAX);
        end else begin
            w_k = w_window_wide[KW-1:0];
        end
    end

    // front candidate expires once its age reaches the window on the next sample
    always_comb begin
        w_drop = w_valid[0] && (({1'b0, w_age[0]} + 1'b1) >= {1'b0, w_k});
        // two stale fronts only after the window shrank: drop one a cycle first
        w_trim = w_drop && w_valid[1] && (({1'b0, w_age[1]} + 1'b1) >= {1'b0, w_k});
    end

    // hold off new samples while trimming or while the result register is blocked
    assign o_stall  = w_trim || (r_out_valid && i_stall);
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        w_ctl.step   = w_accept;
        w_ctl.drop   = w_drop && (w_accept || w_trim);
        w_ctl.clear  = w_accept && i_word.seq_end;
        w_ctl.sample = i_word.sample;
    end

    // fill count and whether this sample completes a window
    always_comb begin
        n_fill     = (r_fill < w_k) ? r_fill + 1'b1 : r_fill;
        w_produced = n_fill >= w_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_accept) begin
            r_fill <= i_word.seq_end ? '0 : n_fill;
        end
    end

    // result register, frees itself when the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_produced;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // front after eviction, or the new sample when the deque empties
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_word.window_max   <= w_keep[0] ? w_cand[0] : i_word.sample;
            r_out_word.final_result <= i_word.seq_end;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

    // cell chain, front at cell 0
    assign w_valid[WINDOW_MAX] = 1'b0;
    assign w_value[WINDOW_MAX] = '0;
    assign w_age[WINDOW_MAX]   = '0;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic w_prev_keep;
        // cell 0 takes the sample whenever it empties
        if (g == 0) begin : g_front
            assign w_prev_keep = 1'b1;
        end else begin : g_body
            assign w_prev_keep = w_keep[g-1];
        end

        swm_cell #(
            .AGE_W (KW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_next_valid (w_valid[g+1]),
            .i_next_value (w_value[g+1]),
            .i_next_age   (w_age[g+1]),
            .i_prev_keep  (w_prev_keep),
            .o_valid      (w_valid[g]),
            .o_value      (w_value[g]),
            .o_age        (w_age[g]),
            .o_keep       (w_keep[g]),
            .o_cand_value (w_cand[g])
        );

        assign w_valid_vec[g] = w_valid[g];
    end

    // occupied cells always form a block starting at the front
    `SWM_ASSERT_NOW(a_chain_compact, i_clk, i_rst_n, 1'b1,
        (w_valid_vec & (w_valid_vec + 1'b1)) == '0, "deque cells not compact")
    // a sample that does not end its sequence always leaves a front candidate
    `SWM_ASSERT_NEXT(a_front_after_step, i_clk, i_rst_n, w_accept && !i_word.seq_end,
        w_valid[0], "deque empty after a sample")
    // the end of a sequence clears deque and fill count
    `SWM_ASSERT_NEXT(a_clear_on_end, i_clk, i_rst_n, w_accept && i_word.seq_end,
        !w_valid[0] && (r_fill == '0), "state not cleared after sequence end")

endmodule

### sv/swm_cell.sv
// one deque cell: holds a candidate value and its age, shifts toward the front
module swm_cell #(
    parameter int AGE_W = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  swm_pkg::t_cell_ctl                 i_ctl,
    input  logic                               i_next_valid,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_next_value,
    input  logic [AGE_W-1:0]                   i_next_age,
    input  logic                               i_prev_keep,
    output logic                               o_valid,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_value,
    output logic [AGE_W-1:0]                   o_age,
    output logic                               o_keep,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_cand_value
);
    import swm_pkg::*;

    logic                       r_valid;
    logic signed [SAMPLE_W-1:0] r_value;
    logic [AGE_W-1:0]           r_age;

    logic                       w_cand_valid;
    logic signed [SAMPLE_W-1:0] w_cand_value;
    logic [AGE_W-1:0]           w_cand_age;

    // content after an optional front drop
    always_comb begin
        w_cand_valid = i_ctl.drop ? i_next_valid : r_valid;
        w_cand_value = i_ctl.drop ? i_next_value : r_value;
        w_cand_age   = i_ctl.drop ? i_next_age   : r_age;
    end

    // survives eviction unless strictly smaller than the new sample
    assign o_keep = w_cand_valid && !($signed(i_ctl.sample) > w_cand_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.step) begin
            r_valid <= o_keep || i_prev_keep;
        end else if (i_ctl.drop) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            if (o_keep) begin
                r_value <= w_cand_value;
                r_age   <= w_cand_age + 1'b1;
            end else begin
                r_value <= i_ctl.sample;
                r_age   <= '0;
            end
        end else if (i_ctl.drop) begin
            r_value <= i_next_value;
            r_age   <= i_next_age;
        end
    end

    assign o_valid      = r_valid;
    assign o_value      = r_value;
    assign o_age        = r_age;
    assign o_cand_value = w_cand_value;

endmodule
